/* src/lspd_pkg.sv */
// Shared types and constants for the lidar scan packet decoder.
`timescale 1ns / 1ps

package lspd_pkg;

  // Fixed field widths
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned AngleWidth   = 15;
  localparam int unsigned DistWidth    = 16;
  localparam int unsigned RangeWidth   = 14;
  localparam int unsigned ZoneWidth    = 3;
  // |end - start| * (k - 1) fits in 23 bits; divisor is sample_count - 1
  localparam int unsigned ProdWidth    = AngleWidth + ByteWidth;
  localparam int unsigned DivisorWidth = ByteWidth;

  typedef logic [ByteWidth-1:0]  byte_t;
  typedef logic [AngleWidth-1:0] angle_t;
  typedef logic [ZoneWidth-1:0]  zone_t;

  // Header byte positions
  localparam byte_t IdxPacketStart = 8'd0;
  localparam byte_t IdxSampleCount = 8'd3;
  localparam byte_t IdxStartAngleHi = 8'd5;
  localparam byte_t IdxEndAngleHi  = 8'd7;
  localparam byte_t IdxLastHeader  = 8'd9;

  localparam logic [RangeWidth-1:0] RangeReset = 14'd400;
  localparam angle_t AngleMax = 15'h7FFF;

  // Zone codes
  localparam zone_t ZoneClear     = 3'd0;
  localparam zone_t ZoneFrontLeft = 3'd1;
  localparam zone_t ZoneFrontRgt  = 3'd2;
  localparam zone_t ZoneSideLeft  = 3'd3;
  localparam zone_t ZoneSideRgt   = 3'd4;

  // Open zone bounds in 1/64 degree
  localparam angle_t Z1Lo = 15'd0;     // 0 deg
  localparam angle_t Z1Hi = 15'd1920;  // 30 deg
  localparam angle_t Z2Lo = 15'd21120; // 330 deg
  localparam angle_t Z2Hi = 15'd23040; // 360 deg
  localparam angle_t Z3Lo = 15'd2560;  // 40 deg
  localparam angle_t Z3Hi = 15'd4480;  // 70 deg
  localparam angle_t Z4Lo = 15'd18560; // 290 deg
  localparam angle_t Z4Hi = 15'd20480; // 320 deg

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StLoad,
    StDiv,
    StFin
  } lspd_state_e;

endpackage

/* src/lspd_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module lspd_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [lspd_pkg::ProdWidth-1:0]       dividend_i,
  input  logic [lspd_pkg::DivisorWidth-1:0]    divisor_i,
  output logic                                 done_o,
  output logic [lspd_pkg::ProdWidth-1:0]       quotient_o
);

  localparam int unsigned DW  = lspd_pkg::ProdWidth;
  localparam int unsigned VW  = lspd_pkg::DivisorWidth;
  localparam int unsigned CW  = $clog2(DW);
  localparam logic [CW-1:0] LastStep = CW'(DW - 1);

  logic            busy_q;
  logic            done_q;
  logic [CW-1:0]   cnt_q;
  logic [DW-1:0]   quo_q, quo_d;
  logic [VW-1:0]   rem_q, rem_d;
  logic [VW-1:0]   den_q;
  logic [VW:0]     trial;
  logic [VW+1:0]   diff;
  logic            ge;

  // shared subtractor
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    diff  = {1'b0, trial} - {2'b00, den_q};
    ge    = ~diff[VW+1];
    rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
    quo_d = {quo_q[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* src/lidar_scan_packet_decoder.sv */
// Top level of the lidar scan packet decoder.
`timescale 1ns / 1ps

// Takes a scan packet one byte per request along with its byte index. Byte 3
// latches the sample count, bytes 4-5 and 6-7 the start and end angle (word
// shifted right by one, 1/64 degree). Every odd index above 9 closes a
// distance word and yields one sample request on the output: interpolated
// angle, raw distance (quarter mm), one-based sample number, last flag and an
// obstacle zone. Index 0 restarts the sample number. Header and idle bytes are
// taken without stalling the input. A sample byte is accepted, then the input
// stalls through the magnitude multiply, the divider load, the bit-serial
// restoring divide of the angle step (23 quotient bits, then the done flag)
// and the finish that registers the result; with a sample count of 0 or 1
// no divide is needed and the sample goes straight to the finish. A finished
// sample waits in the output register while the next bytes are taken; the
// block only stalls at the end of a new sample if that register is still
// full. The obstacle range register resets to 400 mm; the user must write it
// via cfg_we_i/cfg_wdata_i only while idle, which the block does not enforce.

module lidar_scan_packet_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [lspd_pkg::RangeWidth-1:0]     cfg_wdata_i,
  // byte requests
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          data_byte_i,
  input  logic [7:0]                          byte_index_i,
  // sample requests
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [14:0]                         angle_q6_o,
  output logic [15:0]                         distance_q2_o,
  output logic [7:0]                          sample_number_o,
  output logic                                last_sample_o,
  output logic [2:0]                          zone_o
);

  localparam int unsigned PW = lspd_pkg::ProdWidth;
  localparam int unsigned SW = PW + 2; // signed sum, room for sign

  lspd_pkg::lspd_state_e state_q, state_d;

  // header state
  logic [lspd_pkg::RangeWidth-1:0] range_q;
  lspd_pkg::byte_t   count_q;
  lspd_pkg::angle_t  start_q;
  lspd_pkg::angle_t  end_q;
  lspd_pkg::byte_t   hold_q;
  lspd_pkg::byte_t   counter_q;

  // per-sample work registers
  logic [15:0]       word_q;
  lspd_pkg::byte_t   k_q;
  lspd_pkg::byte_t   km1_q;
  logic              last_q;
  logic              direct_q;
  logic              neg_q;
  lspd_pkg::angle_t  mag_q;
  logic [PW-1:0]     prod_q;

  // output register
  logic              out_valid_q;
  lspd_pkg::angle_t  angle_q;
  logic [15:0]       dist_q;
  lspd_pkg::byte_t   num_q;
  logic              olast_q;
  lspd_pkg::zone_t   zone_q;

  logic              in_acc;
  logic              is_sample;
  logic [15:0]       word;
  lspd_pkg::byte_t   k_next;
  logic [15:0]       diff;
  logic              div_start;
  logic              div_done;
  logic [PW-1:0]     quo;
  logic              out_free;
  logic              load_out;
  logic [SW-1:0]     sum;
  lspd_pkg::angle_t  angle;
  lspd_pkg::zone_t   zone;
  logic              dist_hit;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign is_sample = (byte_index_i > lspd_pkg::IdxLastHeader) && byte_index_i[0];
  assign word      = {data_byte_i, hold_q};
  assign k_next    = (counter_q != 8'hFF) ? counter_q + 8'd1 : counter_q;
  assign diff      = {1'b0, end_q} - {1'b0, start_q};
  assign out_free  = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      lspd_pkg::StIdle: begin
        if (in_acc && is_sample) begin
          state_d = (count_q <= 8'd1) ? lspd_pkg::StFin : lspd_pkg::StMul;
        end
      end
      lspd_pkg::StMul:  state_d = lspd_pkg::StLoad;
      lspd_pkg::StLoad: state_d = lspd_pkg::StDiv;
      lspd_pkg::StDiv: begin
        if (div_done) begin
          state_d = lspd_pkg::StFin;
        end
      end
      lspd_pkg::StFin: begin
        if (out_free) begin
          state_d = lspd_pkg::StIdle;
        end
      end
      default: state_d = lspd_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      lspd_pkg::StIdle: in_stall_o = 1'b0;
      lspd_pkg::StLoad: div_start  = 1'b1;
      lspd_pkg::StFin:  load_out   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lspd_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------- header capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q   <= lspd_pkg::RangeReset;
      count_q   <= '0;
      start_q   <= '0;
      end_q     <= '0;
      hold_q    <= '0;
      counter_q <= '0;
    end else begin
      if (cfg_we_i) begin
        range_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        hold_q <= data_byte_i;
        case (byte_index_i)
          lspd_pkg::IdxPacketStart:  counter_q <= '0;
          lspd_pkg::IdxSampleCount:  count_q   <= data_byte_i;
          lspd_pkg::IdxStartAngleHi: start_q   <= word[15:1];
          lspd_pkg::IdxEndAngleHi:   end_q     <= word[15:1];
          default: begin
            if (is_sample) begin
              counter_q <= k_next;
            end
          end
        endcase
      end
    end
  end

  // sample operands, latched on the closing byte
  always_ff @(posedge clk_i) begin
    if (in_acc && is_sample) begin
      word_q   <= word;
      k_q      <= k_next;
      km1_q    <= k_next - 8'd1;
      last_q   <= (k_next == count_q);
      direct_q <= (count_q <= 8'd1);
      neg_q    <= diff[15];
      mag_q    <= diff[15] ? 15'(-diff) : diff[14:0];
    end
    if (state_q == lspd_pkg::StMul) begin
      prod_q <= PW'(mag_q) * PW'(km1_q);
    end
  end

  // angle step: |end - start| * (k - 1) / (count - 1)
  lspd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (count_q - 8'd1),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // ------------------------------------------------------------- finish stage
  always_comb begin
    if (neg_q) begin
      sum = {{(SW-lspd_pkg::AngleWidth){1'b0}}, start_q} - {2'b00, quo};
    end else begin
      sum = {{(SW-lspd_pkg::AngleWidth){1'b0}}, start_q} + {2'b00, quo};
    end
    if (direct_q) begin
      angle = start_q;
    end else if (sum[SW-1]) begin
      angle = '0;
    end else if (sum[SW-2:lspd_pkg::AngleWidth] != '0) begin
      angle = lspd_pkg::AngleMax;
    end else begin
      angle = sum[lspd_pkg::AngleWidth-1:0];
    end
  end

  // obstacle test, zones checked in priority order
  always_comb begin
    dist_hit = (word_q != 16'd0) && (word_q < {range_q, 2'b00});
    zone     = lspd_pkg::ZoneClear;
    if (dist_hit) begin
      if (angle > lspd_pkg::Z1Lo && angle < lspd_pkg::Z1Hi) begin
        zone = lspd_pkg::ZoneFrontLeft;
      end else if (angle > lspd_pkg::Z2Lo && angle < lspd_pkg::Z2Hi) begin
        zone = lspd_pkg::ZoneFrontRgt;
      end else if (angle > lspd_pkg::Z3Lo && angle < lspd_pkg::Z3Hi) begin
        zone = lspd_pkg::ZoneSideLeft;
      end else if (angle > lspd_pkg::Z4Lo && angle < lspd_pkg::Z4Hi) begin
        zone = lspd_pkg::ZoneSideRgt;
      end
    end
  end

  // ------------------------------------------------------------ output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      angle_q <= angle;
      dist_q  <= word_q;
      num_q   <= k_q;
      olast_q <= last_q;
      zone_q  <= zone;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign angle_q6_o      = angle_q;
  assign distance_q2_o   = dist_q;
  assign sample_number_o = num_q;
  assign last_sample_o   = olast_q;
  assign zone_o          = zone_q;

endmodule

/* src/lspd_checker.sv */
// Port-level checks for the lidar scan packet decoder, bound to the top level.
`timescale 1ns / 1ps

module lspd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [7:0]  byte_index_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [14:0] angle_q6_o,
  input  logic [15:0] distance_q2_o,
  input  logic [7:0]  sample_number_o,
  input  logic [2:0]  zone_o
);

  logic hdr_acc;
  assign hdr_acc = in_valid_i && !in_stall_o &&
                   !((byte_index_i > lspd_pkg::IdxLastHeader) && byte_index_i[0]);

  // a stalled sample holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(angle_q6_o) &&
      $stable(distance_q2_o) && $stable(zone_o))
    else $error("stalled sample changed");

  // header bytes never start a computation
  a_hdr_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_acc |=> !in_stall_o)
    else $error("header byte stalled input");

  // an obstacle needs a nonzero distance
  a_zone_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zone_o != lspd_pkg::ZoneClear |-> distance_q2_o != 16'd0)
    else $error("obstacle with zero distance");

  // front-left zone agrees with the angle
  a_zone_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zone_o == lspd_pkg::ZoneFrontLeft |->
      angle_q6_o > lspd_pkg::Z1Lo && angle_q6_o < lspd_pkg::Z1Hi)
    else $error("zone does not match angle");

  // sample numbers are one-based
  a_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_number_o != 8'd0)
    else $error("sample number zero");

endmodule

bind lidar_scan_packet_decoder lspd_checker u_lspd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .byte_index_i    (byte_index_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .angle_q6_o      (angle_q6_o),
  .distance_q2_o   (distance_q2_o),
  .sample_number_o (sample_number_o),
  .zone_o          (zone_o)
);
